>>> hdl/lbt_pkg.sv
// Shared types and constants for the multi-LED blink timer.
`default_nettype none

package lbt_pkg;

  localparam int NUM_LEDS_DEF    = 5;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int MASK_WIDTH      = 5;
  localparam int OUT_WIDTH       = 5;
  localparam int TICK_WIDTH      = 16;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  typedef enum logic [1:0] {
    LED_OFF   = 2'd0,
    LED_ON    = 2'd1,
    LED_BLINK = 2'd2
  } led_cmd_e;

  typedef struct packed {
    logic                  mode;
    logic [MASK_WIDTH-1:0] led_mask;
    logic [1:0]            led_status;
    logic [TICK_WIDTH-1:0] on_ticks;
    logic [TICK_WIDTH-1:0] off_ticks;
    logic [TICK_WIDTH-1:0] duration_ticks;
  } lbt_in_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] led_levels;
    logic [OUT_WIDTH-1:0] blinking_mask;
  } lbt_out_t;

  // Per-LED control from the top level for one accepted transaction.
  typedef struct packed {
    logic       tick;
    logic       sel;
    logic [1:0] status;
  } lbt_ctl_t;

  // Per-LED state after the transaction.
  typedef struct packed {
    logic level;
    logic active;
  } lbt_led_t;

endpackage

`default_nettype wire

>>> hdl/multi_led_blink_timer.sv
// Top level of the multi-LED blink timer: per-LED cells and result register.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------
//   item      | item_valid / item_ready    | item   (lbt_pkg::lbt_in_t)
//   result    | result_valid / result_ready| result (lbt_pkg::lbt_out_t)
//
// One transaction per cycle while not stalled; its result is registered and shows in
// the cycle after acceptance. All LED cells update in parallel at the accepting edge.
// item_ready is low only while a result is held and result_ready is low.
// Synchronous reset turns all LEDs off, stops blinking and drops result_valid.
`default_nettype none

module multi_led_blink_timer #(
  parameter int NUM_LEDS    = lbt_pkg::NUM_LEDS_DEF,
  parameter int COUNT_WIDTH = lbt_pkg::COUNT_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_ready,
  input  wire lbt_pkg::lbt_in_t  item,
  output logic                   result_valid,
  input  wire                    result_ready,
  output lbt_pkg::lbt_out_t      result
);

  localparam int PAD_W = (NUM_LEDS > lbt_pkg::OUT_WIDTH) ? NUM_LEDS : lbt_pkg::OUT_WIDTH;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] on_load, off_load, dur_load;
  logic [NUM_LEDS-1:0]    levels_next, active_next;
  logic [PAD_W-1:0]       levels_pad, active_pad;
  lbt_pkg::lbt_out_t      result_next;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  assign on_load  = COUNT_WIDTH'(item.on_ticks);
  assign off_load = COUNT_WIDTH'(item.off_ticks);
  assign dur_load = COUNT_WIDTH'(item.duration_ticks);

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_led
    lbt_pkg::lbt_ctl_t ctl;
    lbt_pkg::lbt_led_t st;

    always_comb begin
      ctl.tick   = (item.mode == lbt_pkg::MODE_TICK);
      ctl.status = item.led_status;
      if (i < lbt_pkg::MASK_WIDTH) begin
        ctl.sel = (item.mode == lbt_pkg::MODE_CMD) && item.led_mask[i % lbt_pkg::MASK_WIDTH];
      end else begin
        ctl.sel = 1'b0;
      end
    end

    lbt_led_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (accept),
      .ctl       (ctl),
      .on_load   (on_load),
      .off_load  (off_load),
      .dur_load  (dur_load),
      .state_next(st)
    );

    assign levels_next[i] = st.level;
    assign active_next[i] = st.active;
  end

  assign levels_pad = PAD_W'(levels_next);
  assign active_pad = PAD_W'(active_next);

  always_comb begin
    result_next.led_levels    = levels_pad[lbt_pkg::OUT_WIDTH-1:0];
    result_next.blinking_mask = active_pad[lbt_pkg::OUT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lbt_led_cell.sv
// One LED channel: level, blink phase and down counters.
`default_nettype none

module lbt_led_cell #(
  parameter int COUNT_WIDTH = lbt_pkg::COUNT_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire lbt_pkg::lbt_ctl_t       ctl,
  input  wire logic [COUNT_WIDTH-1:0]  on_load,
  input  wire logic [COUNT_WIDTH-1:0]  off_load,
  input  wire logic [COUNT_WIDTH-1:0]  dur_load,
  output lbt_pkg::lbt_led_t            state_next
);

  logic                   level, level_next;
  logic                   active, active_next;
  logic                   phase, phase_next;
  logic [COUNT_WIDTH-1:0] dur_left, dur_left_next;
  logic [COUNT_WIDTH-1:0] phase_left, phase_left_next;
  logic [COUNT_WIDTH-1:0] on_time, on_time_next;
  logic [COUNT_WIDTH-1:0] off_time, off_time_next;
  logic [COUNT_WIDTH-1:0] phase_dec;

  always_comb begin
    level_next      = level;
    active_next     = active;
    phase_next      = phase;
    dur_left_next   = dur_left;
    phase_left_next = phase_left;
    on_time_next    = on_time;
    off_time_next   = off_time;
    // phase counter saturates at zero
    phase_dec = (phase_left != '0) ? (phase_left - COUNT_WIDTH'(1)) : phase_left;

    if (ctl.tick && active) begin
      if (dur_left == '0) begin
        level_next      = 1'b0;
        active_next     = 1'b0;
        phase_next      = 1'b0;
        phase_left_next = '0;
        on_time_next    = '0;
        off_time_next   = '0;
      end else begin
        level_next    = phase;
        dur_left_next = dur_left - COUNT_WIDTH'(1);
        if (phase_dec == '0) begin
          phase_next      = !phase;
          phase_left_next = phase ? off_time : on_time;
        end else begin
          phase_left_next = phase_dec;
        end
      end
    end else if (ctl.sel) begin
      case (ctl.status)
        lbt_pkg::LED_OFF, lbt_pkg::LED_ON: begin
          level_next      = (ctl.status == lbt_pkg::LED_ON);
          active_next     = 1'b0;
          phase_next      = 1'b0;
          dur_left_next   = '0;
          phase_left_next = '0;
          on_time_next    = '0;
          off_time_next   = '0;
        end
        lbt_pkg::LED_BLINK: begin
          on_time_next    = on_load;
          off_time_next   = off_load;
          phase_left_next = on_load;
          dur_left_next   = dur_load;
          phase_next      = 1'b1;
          active_next     = 1'b1;
        end
        default: ;
      endcase
    end

    state_next.level  = level_next;
    state_next.active = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= 1'b0;
      active <= 1'b0;
      phase  <= 1'b0;
    end else if (en) begin
      level  <= level_next;
      active <= active_next;
      phase  <= phase_next;
    end
  end

  // counters are only read while active, and a blink command loads them all
  always_ff @(posedge clk) begin
    if (en) begin
      dur_left   <= dur_left_next;
      phase_left <= phase_left_next;
      on_time    <= on_time_next;
      off_time   <= off_time_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lbt_checker.sv
// Port-level checks for the multi-LED blink timer, bound to the top level.
`default_nettype none

module lbt_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    item_valid,
  input wire                    item_ready,
  input wire lbt_pkg::lbt_in_t  item,
  input wire                    result_valid,
  input wire                    result_ready,
  input wire lbt_pkg::lbt_out_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid set after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> result_valid)
    else $error("accepted transaction gave no result");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |-> !item_ready)
    else $error("item accepted while result is stalled");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  a_all_off_stops_blink: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.mode == lbt_pkg::MODE_CMD &&
     item.led_mask == 5'h1f && item.led_status == lbt_pkg::LED_OFF)
    |=> (result.blinking_mask == 5'h00 && result.led_levels == 5'h00))
    else $error("all-off command left an LED lit or blinking");

endmodule

bind multi_led_blink_timer lbt_checker u_lbt_checker (.*);

`default_nettype wire
